@@ src/prcs_pkg.sv @@
// Shared types and constants for the path root and cut scanner.
package prcs_pkg;

  localparam int unsigned CAP_W        = 16;
  localparam int unsigned IDX_W        = 16;
  localparam int unsigned UNIT_W       = 16;
  localparam int unsigned OUT_TDATA_W  = 72;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'h8000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Scan state summary handed from the scanner to the result logic.
  typedef struct packed {
    logic [IDX_W-1:0] n;
    logic [IDX_W-1:0] rl;
    logic [IDX_W-1:0] last_sep;
    logic             seen;
    logic             sep_before;
    logic             unc;
    logic             ovf;
  } scan_sum_t;

  // Packed so that status lands in the lowest bits.
  typedef struct packed {
    logic [IDX_W-1:0] extra_index;
    logic             extra_valid;
    logic [IDX_W-1:0] trailing_index;
    logic             trailing_valid;
    logic [IDX_W-1:0] cut_index;
    logic             cut_valid;
    logic [IDX_W-1:0] result_length;
    status_t          status;
  } result_t;

endpackage

@@ src/path_root_and_cut_scanner_core.sv @@
// Top level of the path root and cut scanner: input stage, scanner, result register.
//
// Usage:
//   The input stream carries one 16-bit code unit per transfer in in_tdata; in_tlast
//   high marks the terminator transfer that closes the path (its tdata is ignored).
//   Each code unit is registered, then updates the prefix machine and separator
//   tracker in the next cycle. Only the terminator produces a result: one transfer
//   on the output stream, loaded into the result register as the terminator leaves
//   the input stage. Throughput is one code unit per cycle while no terminator
//   waits for the result slot, limited by the single scanner state update per cycle.
//   cfg_wr_en writes the buffer capacity from cfg_wr_data; write it only while idle.
//   Reset (rst_n low, synchronous) empties both registers, starts a new string and
//   sets the capacity to 32768. No clearing pass is needed.
//   When out_tready is low, a pending result holds; code units keep flowing until a
//   second terminator reaches the input stage, which then waits for the result slot.
module path_root_and_cut_scanner_core #(
  parameter int unsigned MAX_CCH = 32768
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [prcs_pkg::UNIT_W-1:0]        in_tdata,    // code_unit
  input  logic                               in_tlast,    // end_of_string
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status, result_length, cut_valid, cut_index, trailing_valid, trailing_index,
  // extra_valid, extra_index, zero fill
  output logic [prcs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [prcs_pkg::CAP_W-1:0]         cfg_wr_data
);
  import prcs_pkg::*;

  localparam int unsigned RES_W = $bits(result_t);

  logic              s_valid_r;
  logic [UNIT_W-1:0] s_code_r;
  logic              s_eos_r;
  logic              out_valid_r;
  result_t           res_r;
  result_t           res;
  scan_sum_t         sum;
  logic [CAP_W-1:0]  cap_r;
  logic              out_free, s_go, take, clear, accept;

  assign out_free  = !out_valid_r || out_tready;
  assign s_go      = s_valid_r && (!s_eos_r || out_free);
  assign in_tready = !s_valid_r || s_go;
  assign accept    = in_tvalid && in_tready;
  assign take      = s_go && !s_eos_r;
  assign clear     = s_go && s_eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (accept) begin
      s_valid_r <= 1'b1;
    end else if (s_go) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_code_r <= in_tdata;
      s_eos_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  prcs_scan #(.MAX_CCH(MAX_CCH)) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .clear (clear),
    .code  (s_code_r),
    .sum   (sum)
  );

  prcs_finish #(.MAX_CCH(MAX_CCH)) u_finish (
    .sum (sum),
    .cap (cap_r),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (clear) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RES_W)'(0), res_r};

  a_unit_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && !s_eos_r) |-> in_tready) else $error("code unit stalled");
  a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (sum.n == '0 && !sum.seen && !sum.ovf)) else $error("scan not restarted");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == ST_INVALID) |-> res_r.result_length == '0 &&
    !res_r.cut_valid && !res_r.trailing_valid && !res_r.extra_valid)
    else $error("invalid result carries data");
  a_trail_needs_cut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((res_r.trailing_valid || res_r.extra_valid) && !res_r.cut_valid))
    else $error("cleared slot without cut");

endmodule

@@ src/prcs_scan.sv @@
// Prefix state machine and separator tracker, one code unit per cycle while take is high.
module prcs_scan #(
  parameter int unsigned MAX_CCH = 32768
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic                         clear,
  input  logic [prcs_pkg::UNIT_W-1:0]  code,
  output prcs_pkg::scan_sum_t          sum
);
  import prcs_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_CCH + 1);
  localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_CCH);

  localparam logic [UNIT_W-1:0] C_BSLASH = 16'h005C;
  localparam logic [UNIT_W-1:0] C_COLON  = 16'h003A;
  localparam logic [UNIT_W-1:0] C_QMARK  = 16'h003F;
  localparam logic [UNIT_W-1:0] C_UP_U   = 16'h0055;
  localparam logic [UNIT_W-1:0] C_LO_U   = 16'h0075;
  localparam logic [UNIT_W-1:0] C_UP_N   = 16'h004E;
  localparam logic [UNIT_W-1:0] C_LO_N   = 16'h006E;
  localparam logic [UNIT_W-1:0] C_UP_C   = 16'h0043;
  localparam logic [UNIT_W-1:0] C_LO_C   = 16'h0063;

  typedef enum logic [3:0] {
    PH_START, PH_D1, PH_D2, PH_S1, PH_S2, PH_Q3, PH_Q4, PH_QU5,
    PH_QD5, PH_QN6, PH_QC7, PH_QD6, PH_SERVER, PH_SHFIRST, PH_SHARE, PH_DONE
  } phase_t;

  function automatic logic letter_ok(input logic [UNIT_W-1:0] c);
    letter_ok = (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
                (c >= 16'h00C0 && c <= 16'h00D6) || (c >= 16'h00D8 && c <= 16'h00F6) ||
                (c >= 16'h00F8 && c <= 16'h00FF);
  endfunction

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] root_r, root_nxt;
  logic [POS_W-1:0] srv_end_r, srv_end_nxt;
  logic [POS_W-1:0] last_sep_r, last_sep_nxt;
  logic             unc_r, unc_nxt;
  logic             seen_r, seen_nxt;
  logic             sep_before_r, sep_before_nxt;
  logic             prev_sep_r, prev_sep_nxt;
  logic             ovf_r, ovf_nxt;
  logic             sep;
  logic [POS_W-1:0] rl;
  logic             unc_eff;

  assign sep = (code == C_BSLASH);

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    root_nxt       = root_r;
    srv_end_nxt    = srv_end_r;
    last_sep_nxt   = last_sep_r;
    unc_nxt        = unc_r;
    seen_nxt       = seen_r;
    sep_before_nxt = sep_before_r;
    prev_sep_nxt   = prev_sep_r;
    ovf_nxt        = ovf_r;
    if (clear) begin
      phase_nxt      = PH_START;
      pos_nxt        = '0;
      root_nxt       = '0;
      srv_end_nxt    = '0;
      last_sep_nxt   = '0;
      unc_nxt        = 1'b0;
      seen_nxt       = 1'b0;
      sep_before_nxt = 1'b0;
      prev_sep_nxt   = 1'b0;
      ovf_nxt        = 1'b0;
    end else if (take && !ovf_r) begin
      if (pos_r >= MAX_P) begin
        ovf_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_START: begin
            if (sep) phase_nxt = PH_S1;
            else if (letter_ok(code)) phase_nxt = PH_D1;
            else begin phase_nxt = PH_DONE; root_nxt = '0; end
          end
          PH_D1: begin
            if (code == C_COLON) phase_nxt = PH_D2;
            else begin phase_nxt = PH_DONE; root_nxt = '0; end
          end
          PH_D2: begin
            phase_nxt = PH_DONE;
            root_nxt  = sep ? POS_W'(3) : POS_W'(2);
          end
          PH_S1: begin
            if (sep) phase_nxt = PH_S2;
            else begin phase_nxt = PH_DONE; root_nxt = POS_W'(1); end
          end
          PH_S2: begin
            if (code == C_QMARK) begin
              phase_nxt = PH_Q3;
            end else begin
              unc_nxt = 1'b1;
              if (sep) begin
                srv_end_nxt = pos_r;
                phase_nxt   = PH_SHFIRST;
              end else begin
                phase_nxt = PH_SERVER;
              end
            end
          end
          PH_Q3: begin
            if (sep) phase_nxt = PH_Q4;
            else begin phase_nxt = PH_DONE; root_nxt = POS_W'(1); end
          end
          PH_Q4: begin
            if (code == C_UP_U || code == C_LO_U) phase_nxt = PH_QU5;
            else if (letter_ok(code)) phase_nxt = PH_QD5;
            else begin phase_nxt = PH_DONE; root_nxt = POS_W'(1); end
          end
          PH_QU5: begin
            if (code == C_UP_N || code == C_LO_N) phase_nxt = PH_QN6;
            else if (code == C_COLON) phase_nxt = PH_QD6;
            else begin phase_nxt = PH_DONE; root_nxt = POS_W'(1); end
          end
          PH_QD5: begin
            if (code == C_COLON) phase_nxt = PH_QD6;
            else begin phase_nxt = PH_DONE; root_nxt = POS_W'(1); end
          end
          PH_QN6: begin
            if (code == C_UP_C || code == C_LO_C) phase_nxt = PH_QC7;
            else begin phase_nxt = PH_DONE; root_nxt = POS_W'(1); end
          end
          PH_QC7: begin
            if (sep) begin
              unc_nxt   = 1'b1;
              phase_nxt = PH_SERVER;
            end else begin
              phase_nxt = PH_DONE;
              root_nxt  = POS_W'(1);
            end
          end
          PH_QD6: begin
            phase_nxt = PH_DONE;
            root_nxt  = sep ? POS_W'(7) : POS_W'(6);
          end
          PH_SERVER: begin
            if (sep) begin
              srv_end_nxt = pos_r;
              phase_nxt   = PH_SHFIRST;
            end
          end
          PH_SHFIRST: begin
            if (sep) begin phase_nxt = PH_DONE; root_nxt = srv_end_r; end
            else phase_nxt = PH_SHARE;
          end
          PH_SHARE: begin
            if (sep) begin phase_nxt = PH_DONE; root_nxt = pos_r; end
          end
          default: ;
        endcase
        if (sep) begin
          last_sep_nxt   = pos_r;
          seen_nxt       = 1'b1;
          sep_before_nxt = prev_sep_r;
        end
        prev_sep_nxt = sep;
        pos_nxt      = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      pos_r        <= '0;
      root_r       <= '0;
      srv_end_r    <= '0;
      last_sep_r   <= '0;
      unc_r        <= 1'b0;
      seen_r       <= 1'b0;
      sep_before_r <= 1'b0;
      prev_sep_r   <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      root_r       <= root_nxt;
      srv_end_r    <= srv_end_nxt;
      last_sep_r   <= last_sep_nxt;
      unc_r        <= unc_nxt;
      seen_r       <= seen_nxt;
      sep_before_r <= sep_before_nxt;
      prev_sep_r   <= prev_sep_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  // Root length as seen if the string ended now.
  always_comb begin
    unc_eff = unc_r;
    case (phase_r)
      PH_START, PH_D1:     rl = '0;
      PH_D2:               rl = POS_W'(2);
      PH_S2: begin
        rl      = POS_W'(2);
        unc_eff = 1'b1;
      end
      PH_QD6:              rl = POS_W'(6);
      PH_SERVER, PH_SHARE: rl = pos_r;
      PH_SHFIRST:          rl = srv_end_r;
      PH_DONE:             rl = root_r;
      default:             rl = POS_W'(1);
    endcase
  end

  assign sum.n          = IDX_W'(pos_r);
  assign sum.rl         = IDX_W'(rl);
  assign sum.last_sep   = IDX_W'(last_sep_r);
  assign sum.seen       = seen_r;
  assign sum.sep_before = sep_before_r;
  assign sum.unc        = unc_eff;
  assign sum.ovf        = ovf_r;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAX_P) else $error("position past maximum");
  a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pos_r == MAX_P) else $error("overflow below maximum");
  a_sep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> last_sep_r < pos_r) else $error("separator beyond position");

endmodule

@@ src/prcs_finish.sv @@
// Cut, cleared slots and status from the scan summary on the terminator.
module prcs_finish #(
  parameter int unsigned MAX_CCH = 32768
) (
  input  prcs_pkg::scan_sum_t         sum,
  input  logic [prcs_pkg::CAP_W-1:0]  cap,
  output prcs_pkg::result_t           res
);
  import prcs_pkg::*;

  localparam logic [IDX_W:0] MAX_W = (IDX_W+1)'(MAX_CCH);

  logic             cut, trail, extra, bad;
  logic [IDX_W-1:0] j_dec, j_inc, end_len;
  logic [IDX_W:0]   hi;

  assign j_dec = sum.last_sep - IDX_W'(1);
  assign j_inc = sum.last_sep + IDX_W'(1);
  assign cut   = sum.seen && (sum.last_sep >= sum.rl);
  assign trail = cut && (sum.last_sep > sum.rl) && sum.sep_before;
  assign extra = cut && (sum.last_sep == sum.rl) && sum.unc;

  always_comb begin
    end_len = sum.rl;
    hi      = {1'b0, sum.rl};
    if (cut) begin
      end_len = trail ? j_dec : sum.last_sep;
      hi      = extra ? {1'b0, j_inc} : {1'b0, sum.last_sep};
    end
  end

  assign bad = sum.ovf || (cap == '0) || ({1'b0, cap} > MAX_W) ||
               ({1'b0, cap} < hi + (IDX_W+1)'(1));

  always_comb begin
    res = '0;
    if (bad) begin
      res.status = ST_INVALID;
    end else if (end_len == sum.n) begin
      res.status        = ST_NONE;
      res.result_length = sum.n;
    end else begin
      res.status         = ST_OK;
      res.result_length  = end_len;
      res.cut_valid      = cut;
      res.cut_index      = cut ? sum.last_sep : '0;
      res.trailing_valid = trail;
      res.trailing_index = trail ? j_dec : '0;
      res.extra_valid    = extra;
      res.extra_index    = extra ? j_inc : '0;
    end
  end

endmodule
